FILE: rtl/core/intel_hex_record_encoder_defines.svh
// Assertion macros shared by the Intel HEX record encoder checkers.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef INTEL_HEX_RECORD_ENCODER_DEFINES_SVH
`define INTEL_HEX_RECORD_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHRE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IHRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ihre_pkg.sv
// Package for the Intel HEX record encoder: sizes, character codes and types.
// No dependencies; the store, emitter, top level and checker import it.
package ihre_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int IDX_W        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int FILL_W       = $clog2(RECORD_BYTES + 1);
  localparam int REC_CHARS    = 12 + 2 * RECORD_BYTES;
  localparam int CI_W         = $clog2(REC_CHARS);
  localparam int HDR_CHARS    = 9;
  localparam int CHK_POS      = HDR_CHARS + 2 * RECORD_BYTES;

  localparam logic [7:0]  COUNT_BYTE = 8'(RECORD_BYTES);
  localparam logic [15:0] ADDR_STEP  = 16'(RECORD_BYTES);
  localparam logic [7:0]  TYPE_DATA  = 8'h00;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } emit_state_t;

  // Handed from the byte store to the emitter when a group completes.
  typedef struct packed {
    logic        start;
    logic [15:0] addr;
    logic [7:0]  check;
  } rec_start_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else begin
      ch = CH_UPPER_A + {4'd0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

FILE: rtl/core/ihre_if.sv
// Valid/ready channel interfaces for the Intel HEX record encoder.
// Stand-alone: payload widths are fixed by the record format.
interface ihre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface ihre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_char;
  logic       record_end;

  modport source (output valid, output hex_char, output record_end, input ready);
  modport sink   (input valid, input hex_char, input record_end, output ready);
endinterface

FILE: rtl/core/ihre_store.sv
// Byte store: the group buffer memory, fill count, running sum and address.
// Depends on ihre_pkg.
module ihre_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [7:0]                data_byte,
  input  logic                      end_of_data,
  input  logic [ihre_pkg::IDX_W-1:0] rd_addr,
  output logic [7:0]                rd_data,
  output ihre_pkg::rec_start_t      rec
);
  import ihre_pkg::*;

  logic [7:0]        mem [RECORD_BYTES];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [7:0]        running_sum;
  logic [7:0]        running_sum_next;
  logic [15:0]       record_address;
  logic [15:0]       record_address_next;
  logic [7:0]        sum_new;
  logic [7:0]        total;
  logic              complete;

  // Buffer memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[IDX_W-1:0]] <= data_byte;
    end
    rd_data <= mem[rd_addr];
  end

  assign sum_new  = running_sum + data_byte;
  assign complete = (fill == FILL_W'(RECORD_BYTES - 1));
  assign total    = COUNT_BYTE + record_address[15:8] + record_address[7:0] + sum_new;

  always_comb begin
    rec.start = wr_en && complete;
    rec.addr  = record_address;
    rec.check = 8'd0 - total;
  end

  always_comb begin
    fill_next           = fill;
    running_sum_next    = running_sum;
    record_address_next = record_address;
    if (wr_en) begin
      if (complete) begin
        fill_next           = '0;
        running_sum_next    = '0;
        record_address_next = record_address + ADDR_STEP;
      end else begin
        fill_next        = fill + FILL_W'(1);
        running_sum_next = sum_new;
      end
      if (end_of_data) begin
        fill_next           = '0;
        running_sum_next    = '0;
        record_address_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      running_sum    <= '0;
      record_address <= '0;
    end else begin
      fill           <= fill_next;
      running_sum    <= running_sum_next;
      record_address <= record_address_next;
    end
  end

endmodule

FILE: rtl/core/ihre_emit.sv
// Record emitter: steps through the characters of one record and drives the
// output register. Depends on ihre_pkg and ihre_if.
module ihre_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  ihre_pkg::rec_start_t       rec,
  output logic [ihre_pkg::IDX_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output logic                       busy,
  ihre_out_if.source                 char_out
);
  import ihre_pkg::*;

  emit_state_t     state;
  emit_state_t     state_next;
  logic [CI_W-1:0] ci;
  logic [CI_W-1:0] ci_next;
  logic [CI_W-1:0] off_next;
  logic [15:0]     rec_addr;
  logic [7:0]      rec_check;
  logic            out_valid;
  logic            out_valid_next;
  logic [7:0]      out_char;
  logic            out_end;
  logic            out_load;
  logic            last_char;
  logic [7:0]      pair_byte;
  logic [3:0]      nib;
  logic [7:0]      ch;

  assign last_char = (ci == CI_W'(REC_CHARS - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rec.start) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && last_char) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    out_load = 1'b0;
    busy     = 1'b0;
    case (state)
      ST_IDLE: begin
        out_load = 1'b0;
        busy     = 1'b0;
      end
      ST_EMIT: begin
        out_load = !out_valid || char_out.ready;
        busy     = 1'b1;
      end
      default: begin
        out_load = 1'b0;
        busy     = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (rec.start) begin
      ci_next = '0;
    end else if (out_load) begin
      ci_next = last_char ? '0 : ci + CI_W'(1);
    end else begin
      ci_next = ci;
    end
  end

  // The read is issued for the character that will be current next cycle,
  // so the registered data lines up with ci.
  assign off_next = ci_next - CI_W'(HDR_CHARS);
  always_comb begin
    if (ci_next >= CI_W'(HDR_CHARS) && ci_next < CI_W'(CHK_POS)) begin
      rd_addr = IDX_W'(off_next >> 1);
    end else begin
      rd_addr = '0;
    end
  end

  // Byte shown by the current pair of hex digits; odd positions hold the
  // high nibble.
  always_comb begin
    if (ci < CI_W'(3)) begin
      pair_byte = COUNT_BYTE;
    end else if (ci < CI_W'(5)) begin
      pair_byte = rec_addr[15:8];
    end else if (ci < CI_W'(7)) begin
      pair_byte = rec_addr[7:0];
    end else if (ci < CI_W'(HDR_CHARS)) begin
      pair_byte = TYPE_DATA;
    end else if (ci < CI_W'(CHK_POS)) begin
      pair_byte = rd_data;
    end else begin
      pair_byte = rec_check;
    end
    nib = ci[0] ? pair_byte[7:4] : pair_byte[3:0];
    if (ci == '0) begin
      ch = CH_COLON;
    end else if (last_char) begin
      ch = CH_NEWLINE;
    end else begin
      ch = hex_digit(nib);
    end
  end

  assign out_valid_next = out_load ? 1'b1 : (char_out.ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ci        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ci        <= ci_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rec.start) begin
      rec_addr  <= rec.addr;
      rec_check <= rec.check;
    end
    if (out_load) begin
      out_char <= ch;
      out_end  <= last_char;
    end
  end

  assign char_out.valid      = out_valid;
  assign char_out.hex_char   = out_char;
  assign char_out.record_end = out_end;

endmodule

FILE: rtl/core/intel_hex_record_encoder.sv
// Top level of the Intel HEX record encoder: joins the byte store and the
// record emitter. Depends on ihre_pkg, ihre_if, ihre_store and ihre_emit.
//
//   Channel    Direction  Payload                   Transaction
//   byte_in    sink       data_byte, end_of_data    one payload byte
//   char_out   source     hex_char, record_end      one record character
//
// A byte is taken in every cycle while the block is collecting a group.
// The byte that completes a group starts a record of 12 + 2*RECORD_BYTES
// characters (44 by default), sent one per cycle through a single output
// register while char_out is not stalled; byte_in is held off while the
// record is emitted, and output stalls stretch the record.
// Reset (rst, synchronous) clears the counters and address at once; the
// buffer needs no clearing pass.
module intel_hex_record_encoder (
  input  logic      clk,
  input  logic      rst,
  ihre_in_if.sink   byte_in,
  ihre_out_if.source char_out
);
  import ihre_pkg::*;

  logic             wr_en;
  logic             busy;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  rec_start_t       rec;

  // Bytes are taken whenever the emitter is not walking through a record.
  // Buffer reads that the emitter uses happen only while a record is emitted
  // and writes only while collecting, so a used read never meets a write.
  // The newline of a record may still wait in the output register while
  // the first byte of the next group is accepted.
  assign byte_in.ready = !busy;
  assign wr_en         = byte_in.valid && byte_in.ready;

  // Group buffer, fill count, running checksum sum and record address.
  ihre_store u_store (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .data_byte   (byte_in.data_byte),
    .end_of_data (byte_in.end_of_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .rec         (rec)
  );

  // Character sequencer with the output register.
  ihre_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .rec      (rec),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .busy     (busy),
    .char_out (char_out)
  );

endmodule

FILE: rtl/core/ihre_checker.sv
// Port-level checker for the Intel HEX record encoder, bound to the top level.
// Depends on ihre_pkg, intel_hex_record_encoder_defines.svh and the top level's ports.
`include "intel_hex_record_encoder_defines.svh"

module ihre_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] hex_char,
  input logic       record_end
);
  import ihre_pkg::*;

  `IHRE_ASSERT_IMPL(a_end_is_newline, out_valid && record_end, hex_char == CH_NEWLINE,
                    "record end without newline")
  `IHRE_ASSERT_IMPL(a_no_input_mid_record, out_valid && !record_end,
                    !(in_valid && in_ready), "byte accepted mid-record")
  `IHRE_ASSERT_NEXT(a_colon_after_record, out_valid && out_ready && record_end,
                    !out_valid || hex_char == CH_COLON, "record not followed by a colon")
  `IHRE_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                    out_valid && $stable(hex_char), "stalled character changed")

endmodule

bind intel_hex_record_encoder ihre_checker u_ihre_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (byte_in.valid),
  .in_ready   (byte_in.ready),
  .out_valid  (char_out.valid),
  .out_ready  (char_out.ready),
  .hex_char   (char_out.hex_char),
  .record_end (char_out.record_end)
);

FILE: dv/tb_intel_hex_record_encoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for intel_hex_record_encoder: valid/ready stimulus and a scoreboard.
// Depends on ihre_pkg, the ihre_in_if/ihre_out_if interfaces and the encoder RTL.
module tb_intel_hex_record_encoder;
  import ihre_pkg::*;

  // One character of record text as it should leave the block.
  typedef struct packed {
    logic [7:0] hex_char;
    logic       record_end;
  } rec_char_t;

  // A directed row sends `count` copies of `value`. When `end_last` is set, the last
  // byte of the row carries end_of_data. A non-empty `text` is the record that the
  // final byte of the row must produce, written out by hand.
  typedef struct {
    int unsigned count;
    logic [7:0]  value;
    logic        end_last;
    string       text;
  } dir_row_t;

  // How busy one side of the link is. The settings are a quiet stretch, full random
  // gaps and a light sprinkling of gaps for the closing run of whole groups.
  typedef enum {
    IDLE_NONE,
    IDLE_FULL,
    IDLE_LIGHT
  } idle_mode_t;

  localparam int      RANDOM_ITEMS = 260;
  // A few whole groups without end of data, so the record address keeps climbing.
  localparam int      CLIMB_ITEMS  = 4 * RECORD_BYTES;
  // Well over the slowest correct run, taken several times over.
  localparam longint  TIMEOUT_NS   = 100_000_000;
  localparam bit [127:0] DIGIT_TEXT = "0123456789ABCDEF";

  logic clk;
  logic rst;

  ihre_in_if  byte_if ();
  ihre_out_if char_if ();

  intel_hex_record_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if),
    .char_out (char_if)
  );

  // Free-running clock: 10 ns high, 10 ns low.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Safety net. If the run stalls anywhere, it is stopped here and declared a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the encoder. It keeps its own copy of the group buffer, the fill
  // level, the running byte sum and the address of the next record. encode_byte
  // advances that state by one accepted byte. It leaves in rec_text the characters
  // that the byte releases, which is either nothing or one whole record.
  // ---------------------------------------------------------------------------
  logic [7:0]        grp_bytes [RECORD_BYTES];
  logic [FILL_W-1:0] grp_fill;
  logic [7:0]        grp_sum;
  logic [15:0]       rec_addr;
  rec_char_t         rec_text [$];

  // Characters still owed by the block, oldest first.
  rec_char_t         pending_chars [$];

  int                mismatches = 0;
  idle_mode_t        tx_mode;
  idle_mode_t        rx_mode;
  int                rx_hold;

  // Appends the two uppercase hex digits of one byte, high nibble first.
  function automatic void put_hex(input logic [7:0] v);
    rec_text.push_back('{DIGIT_TEXT[8 * (15 - v[7:4]) +: 8], 1'b0});
    rec_text.push_back('{DIGIT_TEXT[8 * (15 - v[3:0]) +: 8], 1'b0});
  endfunction

  function automatic void encode_byte(input logic [7:0] d, input logic last);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] check;
    int         k;
    rec_text.delete();
    if (grp_fill < FILL_W'(RECORD_BYTES)) begin
      grp_bytes[grp_fill[IDX_W-1:0]] = d;
    end
    grp_fill = grp_fill + FILL_W'(1);
    grp_sum  = grp_sum + d;
    if (grp_fill >= FILL_W'(RECORD_BYTES)) begin
      hi    = rec_addr[15:8];
      lo    = rec_addr[7:0];
      // The two's complement of the sum over count, address, type and data. The type
      // is zero, so it adds nothing to the sum.
      check = 8'h00 - (8'(RECORD_BYTES) + hi + lo + grp_sum);
      rec_text.push_back('{CH_COLON, 1'b0});
      put_hex(8'(RECORD_BYTES));
      put_hex(hi);
      put_hex(lo);
      put_hex(TYPE_DATA);
      for (k = 0; k < RECORD_BYTES; k++) begin
        put_hex(grp_bytes[k]);
      end
      put_hex(check);
      rec_text.push_back('{CH_NEWLINE, 1'b1});
      rec_addr = rec_addr + 16'(RECORD_BYTES);
      grp_fill = '0;
      grp_sum  = '0;
    end
    // End of data is handled after any record that the byte completes. It drops a
    // partial group and sends the address back to zero.
    if (last) begin
      grp_fill = '0;
      grp_sum  = '0;
      rec_addr = '0;
    end
  endfunction

  // Gap length in cycles. Most gaps are zero or short; only the full mode now and then gives a long one.
  function automatic int pick_idle(input idle_mode_t m);
    int r;
    r = $urandom_range(0, 99);
    case (m)
      IDLE_NONE: begin
        return 0;
      end
      IDLE_LIGHT: begin
        return (r < 95) ? 0 : $urandom_range(1, 2);
      end
      default: begin
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
      end
    endcase
  endfunction

  // Payload bytes lean towards the extremes so that all-zero and all-one digits
  // turn up often.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender. valid is raised after an optional gap and held until the block
  // takes the transaction. When no gap follows, valid simply stays high for the
  // next byte. The expectation is raised at the edge where the byte is accepted.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input logic last, input int gap,
                           input string typed);
    int i;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid       <= 1'b1;
    byte_if.data_byte   <= d;
    byte_if.end_of_data <= last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    encode_byte(d, last);
    if (typed.len() != 0) begin
      for (i = 0; i < typed.len(); i++) begin
        pending_chars.push_back('{typed[i], typed[i] == CH_NEWLINE});
      end
    end else begin
      for (i = 0; i < rec_text.size(); i++) begin
        pending_chars.push_back(rec_text[i]);
      end
    end
  endtask

  // Holds the sender off until every owed character has come out.
  task automatic drain_records();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Character sink and scoreboard. Signals are sampled at the rising edge, so the
  // values seen are those from before the edge. Each accepted character is
  // compared against the oldest expectation. Stalls on ready follow rx_mode.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : char_sink
    rec_char_t want;
    if (rst) begin
      char_if.ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        if (pending_chars.size() == 0) begin
          $error("hex_char: expected none, actual %h", char_if.hex_char);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          if (char_if.hex_char !== want.hex_char) begin
            $error("hex_char: expected %h, actual %h", want.hex_char, char_if.hex_char);
            mismatches++;
          end
          if (char_if.record_end !== want.record_end) begin
            $error("record_end: expected %b, actual %b", want.record_end,
                   char_if.record_end);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        char_if.ready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else begin
        char_if.ready <= 1'b1;
        rx_hold = pick_idle(rx_mode);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: a short directed table, then random groups with gaps on both sides,
  // then a lightly idled run of whole groups with the address climbing.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t dir_table [3];
    string    zero_record;
    int       row;
    int       j;
    int       sent;
    int       kind;
    int       len;
    logic     end_last;

    byte_if.valid       <= 1'b0;
    byte_if.data_byte   <= 8'h00;
    byte_if.end_of_data <= 1'b0;
    rst                 <= 1'b1;

    tx_mode    = IDLE_NONE;
    rx_mode    = IDLE_NONE;
    grp_fill   = '0;
    grp_sum    = '0;
    rec_addr   = '0;

    // An all-zero group at address zero gives a checksum of 0xF0.
    zero_record = {":10000000", "00000000", "00000000", "00000000", "00000000", "F0\n"};
    // The all-zero record ends the data on its own completing byte, so the address goes
    // back to zero. A short group of ones is then dropped, and five bytes are left open
    // for the random part to finish from address zero.
    dir_table[0] = '{16, 8'h00, 1'b1, zero_record};
    dir_table[1] = '{3,  8'hFF, 1'b1, ""};
    dir_table[2] = '{5,  8'h5A, 1'b0, ""};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < 3; row++) begin
      for (j = 0; j < dir_table[row].count; j++) begin
        send_byte(dir_table[row].value,
                  dir_table[row].end_last && (j == dir_table[row].count - 1),
                  0,
                  (j == dir_table[row].count - 1) ? dir_table[row].text : "");
      end
    end
    drain_records();

    // Random part. Most groups are well formed and run up to the end of the current
    // group. Some of them also end the data on the completing byte. The rest are
    // broken off early by end of data.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind    = $urandom_range(0, 99);
      tx_mode = ($urandom_range(0, 3) == 0) ? IDLE_NONE : IDLE_FULL;
      rx_mode = ($urandom_range(0, 3) == 0) ? IDLE_NONE : IDLE_FULL;
      if (kind < 85) begin
        len      = RECORD_BYTES - int'(grp_fill);
        end_last = (kind >= 70);
      end else begin
        len      = $urandom_range(1, RECORD_BYTES - 1);
        end_last = 1'b1;
      end
      for (j = 0; j < len; j++) begin
        send_byte(pick_byte(), end_last && (j == len - 1), pick_idle(tx_mode), "");
      end
      sent = sent + len;
    end
    drain_records();

    // Whole groups without end of data, so each record sits one step above the last.
    tx_mode = IDLE_LIGHT;
    rx_mode = IDLE_LIGHT;
    for (j = 0; j < CLIMB_ITEMS; j++) begin
      send_byte(pick_byte(), 1'b0, pick_idle(tx_mode), "");
    end
    drain_records();

    // Allow time for any stray character to appear before the verdict.
    repeat (2 * REC_CHARS) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
